### hw/rtl/tutx_pkg.sv
// tutx_pkg: shared types and the UTF-8 encode function for the text extractor.
// No dependencies; imported by the front, queue, back and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package tutx_pkg;

	localparam logic [15:0] TAG_MASK  = 16'hFF00;
	localparam logic [15:0] TAG_VALUE = 16'hF500;
	localparam logic [15:0] PRINT_LO  = 16'h0020;
	localparam logic [15:0] SURR_LO   = 16'hD800;
	localparam logic [15:0] ONE_MAX   = 16'h0080;
	localparam logic [15:0] TWO_MAX   = 16'h0800;
	localparam logic [15:0] LF_UNIT   = 16'h000A;
	localparam logic [15:0] CR_UNIT   = 16'h000D;
	localparam logic [7:0]  LEAD2     = 8'hC0;
	localparam logic [7:0]  LEAD3     = 8'hE0;
	localparam logic [7:0]  CONT      = 8'h80;
	localparam logic [5:0]  LOW6      = 6'h3F;
	localparam logic [7:0]  LF_BYTE   = 8'h0A;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		IDX_B0 = 2'd0,
		IDX_B1 = 2'd1,
		IDX_B2 = 2'd2
	} byte_idx_t;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		byte_idx_t  last_idx;
	} run_t;

	function automatic run_t encode_unit(input logic [15:0] u);
		run_t r;
		r.b0 = 8'h00;
		r.b1 = 8'h00;
		r.b2 = 8'h00;
		r.last_idx = IDX_B0;
		if (u < ONE_MAX) begin
			r.b0 = u[7:0];
		end else if (u < TWO_MAX) begin
			r.b0 = LEAD2 | {3'b000, u[10:6]};
			r.b1 = CONT | {2'b00, u[5:0] & LOW6};
			r.last_idx = IDX_B1;
		end else begin
			r.b0 = LEAD3 | {4'b0000, u[15:12]};
			r.b1 = CONT | {2'b00, u[11:6] & LOW6};
			r.b2 = CONT | {2'b00, u[5:0] & LOW6};
			r.last_idx = IDX_B2;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/tutx_front.sv
// tutx_front: accepts code units, applies tag skipping and filtering, builds byte runs.
// Depends on tutx_pkg; feeds tutx_queue.
`timescale 1ns / 1ps
`default_nettype none

module tutx_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          cfg_wdata,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [15:0]   code_unit,
	input  wire logic          end_of_object,
	input  wire logic          q_full,
	output logic               push,
	output tutx_pkg::run_t     push_run
);
	import tutx_pkg::*;

	logic text_mode_q;
	logic skip_pending_q;
	logic skip_n;
	logic emit;
	logic accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && emit;

	always_comb begin
		emit = 1'b0;
		skip_n = skip_pending_q;
		push_run = encode_unit(code_unit);
		priority if (text_mode_q) begin
			emit = 1'b1;
		end else if (skip_pending_q) begin
			skip_n = 1'b0;
		end else if ((code_unit & TAG_MASK) == TAG_VALUE) begin
			skip_n = 1'b1;
		end else if (code_unit >= PRINT_LO && code_unit < SURR_LO) begin
			emit = 1'b1;
		end else if (code_unit == LF_UNIT || code_unit == CR_UNIT) begin
			emit = 1'b1;
			push_run.b0 = LF_BYTE;
			push_run.last_idx = IDX_B0;
		end else begin
			emit = 1'b0;
		end
		if (end_of_object) begin
			skip_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_mode_q <= 1'b0;
			skip_pending_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				text_mode_q <= cfg_wdata;
			end
			if (accept) begin
				skip_pending_q <= skip_n;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tutx_queue.sv
// tutx_queue: two-entry queue of byte runs between front and back.
// Depends on tutx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tutx_queue (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  tutx_pkg::run_t push_run,
	output logic           full,
	input  wire logic      pop,
	output logic           head_valid,
	output tutx_pkg::run_t head_run
);
	import tutx_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	run_t           mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    count_q;

	assign full       = count_q == (PW+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_run   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tutx_back.sv
// tutx_back: serializes queued runs into one UTF-8 byte per word on the output register.
// Depends on tutx_pkg; reads tutx_queue.
`timescale 1ns / 1ps
`default_nettype none

module tutx_back (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      head_valid,
	input  tutx_pkg::run_t head_run,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output logic [7:0]     utf8_byte,
	output logic           last_byte
);
	import tutx_pkg::*;

	byte_idx_t  idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       advance;
	logic       is_last;
	logic [7:0] sel_byte;

	assign advance   = !out_valid_q || out_ready;
	assign is_last   = idx_q == head_run.last_idx;
	assign pop       = advance && head_valid && is_last;
	assign out_valid = out_valid_q;
	assign utf8_byte = byte_q;
	assign last_byte = last_q;

	always_comb begin
		unique case (idx_q)
			IDX_B0:  sel_byte = head_run.b0;
			IDX_B1:  sel_byte = head_run.b1;
			default: sel_byte = head_run.b2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			byte_q <= sel_byte;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q <= IDX_B0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				unique case ({is_last, idx_q})
					{1'b0, IDX_B0}: idx_q <= IDX_B1;
					{1'b0, IDX_B1}: idx_q <= IDX_B2;
					default:        idx_q <= IDX_B0;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tagged_utf16_text_extractor_core.sv
// tagged_utf16_text_extractor_core: top level, UTF-16LE units in, UTF-8 bytes out.
// Depends on tutx_pkg, tutx_front, tutx_queue, tutx_back.
//
//   channel | ports                                   | handshake
//   in      | code_unit, end_of_object                | in_valid / in_ready
//   out     | utf8_byte, last_byte                    | out_valid / out_ready
//   cfg     | cfg_wdata (text_mode)                   | cfg_we, no wait
//
// A unit gives 0 to 3 bytes; the byte serializer in tutx_back sends them from the output
// register, one byte per cycle while out_ready does not stall it.
// A unit that gives bytes is written to the run queue, then to the output register.
// Reset clears mode, pending skip, queue and output valid.
// in_ready drops only while the two-entry run queue is full.
`timescale 1ns / 1ps
`default_nettype none

module tagged_utf16_text_extractor_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] code_unit,
	input  wire logic        end_of_object,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       utf8_byte,
	output logic             last_byte
);
	import tutx_pkg::*;

	logic push;
	logic pop;
	logic q_full;
	logic head_valid;
	run_t push_run;
	run_t head_run;

	tutx_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.code_unit     (code_unit),
		.end_of_object (end_of_object),
		.q_full        (q_full),
		.push          (push),
		.push_run      (push_run)
	);

	tutx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_run   (push_run),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_run   (head_run)
	);

	tutx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_run   (head_run),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.utf8_byte  (utf8_byte),
		.last_byte  (last_byte)
	);

endmodule

`default_nettype wire

### hw/rtl/tutx_checker.sv
// tutx_checker: port-level assertions for the text extractor core.
// Depends on tagged_utf16_text_extractor_core; bound to it below.
`timescale 1ns / 1ps
`default_nettype none

module tutx_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] utf8_byte,
	input wire logic       last_byte
);

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(utf8_byte) && $stable(last_byte))
		else $error("stalled output word changed");

	a_lead_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_byte |-> utf8_byte[7])
		else $error("non-final word is not a multi-byte byte");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_byte |=> out_valid && utf8_byte[7:6] == 2'b10)
		else $error("run broken or next word not a continuation byte");

endmodule

bind tagged_utf16_text_extractor_core tutx_checker u_tutx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.utf8_byte (utf8_byte),
	.last_byte (last_byte)
);

`default_nettype wire

### verif/tutx_stream_checker.sv
// tutx_stream_checker: watches the unit and byte channels of the text extractor,
// predicts the UTF-8 byte runs and compares them with what the block sends.
// Depends on tutx_pkg for the tag, range and byte constants.
`timescale 1ns / 1ps

module tutx_stream_checker
	import tutx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [15:0] code_unit,
	input  wire logic        end_of_object,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [7:0]  utf8_byte,
	input  wire logic        last_byte,
	output int               fail_count,
	output int               bytes_pending
);

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} utf8_word_t;

	utf8_word_t utf8_due[$];
	logic raw_mode;
	logic skip_pending;
	int mismatches = 0;

	task automatic push_byte(input logic [7:0] value, input logic last);
		utf8_word_t w;
		w.value = value;
		w.last = last;
		utf8_due.insert(utf8_due.size(), w);
	endtask

	task automatic push_utf8_run(input logic [15:0] u);
		if (u < ONE_MAX) begin
			push_byte(u[7:0], 1'b1);
		end else if (u < TWO_MAX) begin
			push_byte(LEAD2 | {3'b000, u[10:6]}, 1'b0);
			push_byte(CONT | {2'b00, u[5:0]}, 1'b1);
		end else begin
			push_byte(LEAD3 | {4'b0000, u[15:12]}, 1'b0);
			push_byte(CONT | {2'b00, u[11:6]}, 1'b0);
			push_byte(CONT | {2'b00, u[5:0]}, 1'b1);
		end
	endtask

	task automatic predict_unit(input logic [15:0] u, input logic eoo);
		if (raw_mode) begin
			push_utf8_run(u);
		end else if (skip_pending) begin
			skip_pending = 1'b0;
		end else if ((u & TAG_MASK) == TAG_VALUE) begin
			skip_pending = 1'b1;
		end else if (u >= PRINT_LO && u < SURR_LO) begin
			push_utf8_run(u);
		end else if (u == LF_UNIT || u == CR_UNIT) begin
			push_byte(LF_BYTE, 1'b1);
		end
		if (eoo) begin
			skip_pending = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		utf8_word_t want;
		if (!arst_n) begin
			utf8_due.delete();
			raw_mode = 1'b0;
			skip_pending = 1'b0;
			bytes_pending <= 0;
			fail_count <= mismatches;
		end else begin
			// check the outgoing word first: it can never stem from a unit taken at this edge
			if (out_valid && out_ready) begin
				if (utf8_due.size() == 0) begin
					$error("unexpected word: utf8_byte %h last_byte %b", utf8_byte, last_byte);
					mismatches++;
				end else begin
					want = utf8_due.pop_front();
					if (utf8_byte !== want.value) begin
						$error("utf8_byte: expected %h, got %h", want.value, utf8_byte);
						mismatches++;
					end
					if (last_byte !== want.last) begin
						$error("last_byte: expected %b, got %b", want.last, last_byte);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_unit(code_unit, end_of_object);
			end
			if (cfg_we) begin
				raw_mode = cfg_wdata;
			end
			bytes_pending <= utf8_due.size();
			fail_count <= mismatches;
		end
	end

endmodule

### verif/tagged_utf16_text_extractor_core_test.sv
// tagged_utf16_text_extractor_core_test: drives code units and byte-channel stalls
// into the text extractor and gives the verdict from tutx_stream_checker.
// Depends on tutx_pkg, tagged_utf16_text_extractor_core and tutx_stream_checker.
`timescale 1ns / 1ps

module tagged_utf16_text_extractor_core_test;
	import tutx_pkg::*;

	localparam logic MODE_TAGGED = 1'b0;
	localparam logic MODE_RAW    = 1'b1;
	localparam int SETTLE_CYCLES    = 4;
	localparam int DRAIN_CYCLES     = 8;
	localparam int SINK_HOLD_CYCLES = 150;
	localparam int IDLE_LIMIT       = 2000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic [15:0] code_unit = '0;
	logic        end_of_object = 1'b0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [7:0]  utf8_byte;
	logic        last_byte;

	int fail_count;
	int bytes_pending;
	int idle_cycles = 0;
	logic mode_now = MODE_TAGGED;
	bit sender_steady = 1'b0;
	bit sink_hold_req = 1'b0;
	bit sink_holding = 1'b0;

	tagged_utf16_text_extractor_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.code_unit    (code_unit),
		.end_of_object(end_of_object),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.utf8_byte    (utf8_byte),
		.last_byte    (last_byte)
	);

	tutx_stream_checker stream_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.code_unit    (code_unit),
		.end_of_object(end_of_object),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.utf8_byte    (utf8_byte),
		.last_byte    (last_byte),
		.fail_count   (fail_count),
		.bytes_pending(bytes_pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] gen_tagged_unit();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) return TAG_VALUE | 16'($urandom_range(0, 255));
		if (pick < 25) return ($urandom_range(0, 1) != 0) ? CR_UNIT : LF_UNIT;
		if (pick < 33) return 16'($urandom());
		if (pick < 40) begin
			if ($urandom_range(0, 1) != 0) return 16'($urandom_range(0, 31));
			return 16'($urandom_range(16'hD800, 16'hFFFF));
		end
		if (pick < 65) return 16'($urandom_range(16'h0020, 16'h007F));
		if (pick < 80) return 16'($urandom_range(16'h0080, 16'h07FF));
		return 16'($urandom_range(16'h0800, 16'hD7FF));
	endfunction

	function automatic logic [15:0] gen_raw_unit();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) return 16'($urandom());
		if (pick < 55) return 16'($urandom_range(16'h0000, 16'h007F));
		if (pick < 75) return 16'($urandom_range(16'h0080, 16'h07FF));
		if (pick < 90) return 16'($urandom_range(16'h0800, 16'hFFFF));
		return 16'($urandom_range(16'hD800, 16'hDFFF));
	endfunction

	task automatic send_unit(input logic [15:0] u, input logic eoo);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		in_valid <= 1'b1;
		code_unit <= u;
		end_of_object <= eoo;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bytes_pending != 0) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_now = m;
	endtask

	task automatic send_random(input int count);
		logic [15:0] u;
		for (int i = 0; i < count; i++) begin
			u = (mode_now == MODE_RAW) ? gen_raw_unit() : gen_tagged_unit();
			send_unit(u, $urandom_range(0, 11) == 0);
		end
	endtask

	// hold the byte channel while units keep coming, so the run queue fills
	task automatic send_against_stall(input int count);
		in_valid <= 1'b0;
		sink_hold_req = 1'b1;
		while (!sink_holding) @(posedge clk);
		sender_steady = 1'b1;
		for (int i = 0; i < count; i++) begin
			send_unit(16'($urandom_range(16'h0800, 16'hD7FF)), 1'b0);
		end
		sender_steady = 1'b0;
	endtask

	initial begin
		int run;
		int gap;
		forever begin
			if (sink_hold_req) begin
				sink_holding = 1'b1;
				out_ready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
				sink_hold_req = 1'b0;
				sink_holding = 1'b0;
			end
			out_ready <= 1'b1;
			run = $urandom_range(1, 24);
			repeat (run) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_mode(MODE_TAGGED);

		send_unit(16'h0020, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hD7FF, 1'b0);
		send_unit(CR_UNIT, 1'b0);
		send_unit(LF_UNIT, 1'b0);
		send_unit(16'h0000, 1'b0);
		send_unit(16'hD800, 1'b0);
		send_unit(16'hF512, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hF500, 1'b0);
		send_unit(16'hF5FF, 1'b0);
		send_unit(16'h0042, 1'b0);
		send_unit(16'hF501, 1'b1);
		send_unit(16'h0043, 1'b0);
		send_unit(16'hF502, 1'b0);

		// skip stays pending across raw mode
		set_mode(MODE_RAW);
		send_unit(16'h0044, 1'b0);
		send_unit(16'h0000, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hDFFF, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		send_unit(16'hF5AA, 1'b0);
		send_unit(CR_UNIT, 1'b0);
		set_mode(MODE_TAGGED);
		send_unit(16'h0045, 1'b0);
		send_unit(16'h0046, 1'b1);

		send_random(20);
		send_against_stall(12);
		send_random(15);
		wait_drained();
		send_random(10);
		set_mode(MODE_RAW);
		send_random(25);
		set_mode(MODE_TAGGED);
		sender_steady = 1'b1;
		send_random(25);
		sender_steady = 1'b0;
		set_mode(MODE_RAW);
		send_random(25);
		set_mode(MODE_TAGGED);
		send_random(21);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/tutx_pkg.sv
hw/rtl/tutx_front.sv
hw/rtl/tutx_queue.sv
hw/rtl/tutx_back.sv
hw/rtl/tagged_utf16_text_extractor_core.sv
hw/rtl/tutx_checker.sv
verif/tutx_stream_checker.sv
verif/tagged_utf16_text_extractor_core_test.sv
